/* rtl/core/pkthc_pkg.sv */
// ----------------------------------------------------------------------------
// pkthc_pkg
// Types and constants shared by the packet header classifier modules.
// ----------------------------------------------------------------------------
package pkthc_pkg;

    // Header offsets and limits, in bytes
    localparam int OFS_ETHERTYPE_HI     = 12;
    localparam int OFS_ETHERTYPE_LO     = 13;
    localparam int OFS_IPV4_IHL         = 14;
    localparam int OFS_IPV4_PROTO       = 23;
    localparam int OFS_IPV6_NEXT_HDR    = 20;
    localparam int OFS_L4_PORT_HI       = 2;
    localparam int OFS_L4_PORT_LO       = 3;
    localparam int OFS_UDP_LEN_HI       = 4;
    localparam int OFS_UDP_LEN_LO       = 5;
    localparam int OFS_TCP_DOFF         = 12;
    localparam int ETH_HDR_LEN          = 14;
    localparam int IPV4_MIN_LEN         = 34;
    localparam int IPV6_MIN_LEN         = 54;
    localparam int IPV4_MIN_HDR         = 20;
    localparam int TCP_MIN_HDR          = 20;
    localparam int UDP_HDR_LEN          = 8;
    localparam int MIN_TRANSPORT_START  = 34;
    localparam int IPV6_TRANSPORT_START = 54;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    // Job queue between parser and counter unit
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        NET_NONE  = 2'd0,
        NET_IPV4  = 2'd1,
        NET_IPV6  = 2'd2,
        NET_OTHER = 2'd3
    } net_kind_t;

    typedef enum logic [1:0] {
        VERDICT_PASS  = 2'd0,
        VERDICT_DROP  = 2'd1,
        VERDICT_ABORT = 2'd2
    } verdict_t;

    typedef enum logic [1:0] {
        CLASS_DROP = 2'd0,
        CLASS_PASS = 2'd1,
        CLASS_NONE = 2'd2
    } count_class_t;

    // Per-packet job handed from the parser to the counter unit
    typedef struct packed {
        logic [15:0]  ether_kind;
        logic         port_rewritten;
        logic [15:0]  new_dest_port;
        logic [6:0]   port_offset;
        count_class_t count_class;
        logic [7:0]   count_slot;
    } pkthc_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pkthc_queue_status_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [3:0]   pad;
        logic [31:0]  count_value;
        logic [7:0]   count_slot;
        count_class_t count_class;
        logic [6:0]   port_offset;
        logic [15:0]  new_dest_port;
        logic         port_rewritten;
        logic [15:0]  ether_kind;
        verdict_t     verdict;
    } pkthc_out_t;

    function automatic verdict_t verdict_of(input count_class_t cls);
        verdict_t v;
        unique case (cls)
            CLASS_DROP: v = VERDICT_DROP;
            CLASS_PASS: v = VERDICT_PASS;
            default:    v = VERDICT_ABORT;
        endcase
        return v;
    endfunction

endpackage

/* rtl/core/pkthc_front.sv */
// ----------------------------------------------------------------------------
// pkthc_front
// Byte parser: captures header fields and forms one job per packet.
// ----------------------------------------------------------------------------
module pkthc_front
    import pkthc_pkg::*;
#(
    parameter int COUNTER_SLOTS = 256,
    parameter int POSITION_BITS = 11
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] pkt_byte,
    input  logic       last_byte,
    output logic       push,
    output pkthc_job_t job
);

    localparam int LEN_W = POSITION_BITS + 1;

    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [15:0]              eth_reg, eth_next, cap_eth;
    net_kind_t                kind_reg, kind_next, cap_kind;
    logic [6:0]               ihl_reg, ihl_next, cap_ihl;
    logic [7:0]               proto_reg, proto_next, cap_proto;
    logic [6:0]               ts_reg, ts_next, cap_ts;
    logic [6:0]               doff_reg, doff_next, cap_doff;
    logic [15:0]              port_reg, port_next, cap_port;
    logic [15:0]              udp_reg, udp_next, cap_udp;

    logic [POSITION_BITS-1:0] ts_pos;
    logic [LEN_W-1:0]         len, ts_len, ihl_len, doff_len;
    logic                     slot_ok, ip_ok, udp_abort, tcp_ok;

    // Field capture for the current byte
    always_comb
    begin
        cap_eth   = eth_reg;
        cap_kind  = kind_reg;
        cap_ihl   = ihl_reg;
        cap_proto = proto_reg;
        cap_ts    = ts_reg;
        cap_doff  = doff_reg;
        cap_port  = port_reg;
        cap_udp   = udp_reg;
        if (pos_reg == POSITION_BITS'(OFS_ETHERTYPE_HI))
        begin
            cap_eth = {pkt_byte, 8'h00};
        end
        else if (pos_reg == POSITION_BITS'(OFS_ETHERTYPE_LO))
        begin
            cap_eth = eth_reg | {8'h00, pkt_byte};
            if (cap_eth == ETH_IPV4)
            begin
                cap_kind = NET_IPV4;
            end
            else if (cap_eth == ETH_IPV6)
            begin
                cap_kind = NET_IPV6;
                cap_ts   = 7'(IPV6_TRANSPORT_START);
            end
            else
            begin
                cap_kind = NET_OTHER;
            end
        end
        else if (pos_reg == POSITION_BITS'(OFS_IPV4_IHL) && kind_reg == NET_IPV4)
        begin
            cap_ihl = {1'b0, pkt_byte[3:0], 2'b00};
            cap_ts  = 7'(ETH_HDR_LEN) + cap_ihl;
        end
        else if ((pos_reg == POSITION_BITS'(OFS_IPV4_PROTO) && kind_reg == NET_IPV4) ||
                 (pos_reg == POSITION_BITS'(OFS_IPV6_NEXT_HDR) && kind_reg == NET_IPV6))
        begin
            cap_proto = pkt_byte;
        end

        ts_pos = POSITION_BITS'(cap_ts);
        if ((cap_kind == NET_IPV4 || cap_kind == NET_IPV6) &&
            cap_ts >= 7'(MIN_TRANSPORT_START))
        begin
            if (pos_reg == ts_pos + POSITION_BITS'(OFS_L4_PORT_HI))
            begin
                cap_port = {pkt_byte, 8'h00};
            end
            else if (pos_reg == ts_pos + POSITION_BITS'(OFS_L4_PORT_LO))
            begin
                cap_port = port_reg | {8'h00, pkt_byte};
            end
            else if (pos_reg == ts_pos + POSITION_BITS'(OFS_UDP_LEN_HI))
            begin
                cap_udp = {pkt_byte, 8'h00};
            end
            else if (pos_reg == ts_pos + POSITION_BITS'(OFS_UDP_LEN_LO))
            begin
                cap_udp = udp_reg | {8'h00, pkt_byte};
            end
            else if (pos_reg == ts_pos + POSITION_BITS'(OFS_TCP_DOFF))
            begin
                cap_doff = {1'b0, pkt_byte[7:4], 2'b00};
            end
        end
    end

    // Header checks on the final byte
    assign len      = LEN_W'(pos_reg) + LEN_W'(1);
    assign ts_len   = LEN_W'(cap_ts);
    assign ihl_len  = LEN_W'(cap_ihl);
    assign doff_len = LEN_W'(cap_doff);
    assign slot_ok  = (17'(cap_eth[15:8]) < 17'(COUNTER_SLOTS));

    always_comb
    begin
        if (cap_kind == NET_IPV6)
        begin
            ip_ok = (len >= LEN_W'(IPV6_MIN_LEN));
        end
        else
        begin
            ip_ok = (len >= LEN_W'(IPV4_MIN_LEN)) && (cap_ihl >= 7'(IPV4_MIN_HDR)) &&
                    (LEN_W'(ETH_HDR_LEN) + ihl_len <= len);
        end
    end

    assign udp_abort = ip_ok && (cap_proto == PROTO_UDP) &&
                       ((len < ts_len + LEN_W'(UDP_HDR_LEN)) ||
                        (cap_udp < 16'(UDP_HDR_LEN)));
    assign tcp_ok    = ip_ok && (cap_proto == PROTO_TCP) &&
                       (len >= ts_len + LEN_W'(TCP_MIN_HDR)) &&
                       (cap_doff >= 7'(TCP_MIN_HDR)) &&
                       (ts_len + doff_len <= len);

    always_comb
    begin
        job = '0;
        job.count_class = CLASS_NONE;
        if (len >= LEN_W'(ETH_HDR_LEN))
        begin
            job.ether_kind = cap_eth;
            job.count_slot = cap_eth[15:8];
            if (slot_ok)
            begin
                if (cap_kind == NET_OTHER)
                begin
                    job.count_class = CLASS_DROP;
                end
                else if (!udp_abort)
                begin
                    job.count_class = CLASS_PASS;
                    if (tcp_ok)
                    begin
                        job.port_rewritten = 1'b1;
                        job.new_dest_port  = cap_port - 16'd1;
                        job.port_offset    = cap_ts + 7'(OFS_L4_PORT_HI);
                    end
                end
            end
        end
    end

    assign push = accept && last_byte;

    // Clear per-packet state after the final byte
    always_comb
    begin
        if (last_byte)
        begin
            pos_next   = '0;
            eth_next   = '0;
            kind_next  = NET_NONE;
            ihl_next   = '0;
            proto_next = '0;
            ts_next    = '0;
            doff_next  = '0;
            port_next  = '0;
            udp_next   = '0;
        end
        else
        begin
            pos_next   = (pos_reg == '1) ? pos_reg : pos_reg + POSITION_BITS'(1);
            eth_next   = cap_eth;
            kind_next  = cap_kind;
            ihl_next   = cap_ihl;
            proto_next = cap_proto;
            ts_next    = cap_ts;
            doff_next  = cap_doff;
            port_next  = cap_port;
            udp_next   = cap_udp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            eth_reg   <= '0;
            kind_reg  <= NET_NONE;
            ihl_reg   <= '0;
            proto_reg <= '0;
            ts_reg    <= '0;
            doff_reg  <= '0;
            port_reg  <= '0;
            udp_reg   <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            eth_reg   <= eth_next;
            kind_reg  <= kind_next;
            ihl_reg   <= ihl_next;
            proto_reg <= proto_next;
            ts_reg    <= ts_next;
            doff_reg  <= doff_next;
            port_reg  <= port_next;
            udp_reg   <= udp_next;
        end
    end

endmodule

/* rtl/core/pkthc_queue.sv */
// ----------------------------------------------------------------------------
// pkthc_queue
// Short job queue between the parser and the counter unit.
// ----------------------------------------------------------------------------
module pkthc_queue
    import pkthc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  pkthc_job_t          job_in,
    input  logic                pop,
    output pkthc_job_t          head,
    output pkthc_queue_status_t status
);

    pkthc_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     count_reg, count_next;

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full && !pop))
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && status.empty))
        else $error("job popped from an empty queue");

endmodule

/* rtl/core/pkthc_back.sv */
// ----------------------------------------------------------------------------
// pkthc_back
// Counter unit: read-modify-write of the drop and pass counters, result
// register.
// ----------------------------------------------------------------------------
module pkthc_back
    import pkthc_pkg::*;
#(
    parameter int COUNTER_SLOTS = 256,
    parameter int COUNT_BITS    = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  pkthc_job_t          head,
    input  pkthc_queue_status_t q_status,
    output logic                pop,
    output logic                clearing,
    output logic                out_valid,
    input  logic                out_ready,
    output pkthc_out_t          out_data
);

    localparam int SLOT_W = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;

    logic [COUNT_BITS-1:0] drop_mem [COUNTER_SLOTS];
    logic [COUNT_BITS-1:0] pass_mem [COUNTER_SLOTS];
    logic [COUNT_BITS-1:0] drop_rd_reg, pass_rd_reg;

    logic                  clr_active_reg;
    logic [SLOT_W-1:0]     clr_addr_reg;

    logic                  b_valid_reg;
    pkthc_job_t            b_job_reg;
    logic [SLOT_W-1:0]     b_idx_reg;

    logic                  fwd_valid_reg;
    count_class_t          fwd_class_reg;
    logic [SLOT_W-1:0]     fwd_idx_reg;
    logic [COUNT_BITS-1:0] fwd_value_reg;

    logic                  out_valid_reg;
    pkthc_out_t            out_data_reg;

    logic [SLOT_W-1:0]     head_idx;
    logic                  b_adv, b_wr_en;
    logic [COUNT_BITS-1:0] base_value, bumped;
    logic                  drop_we, pass_we;
    logic [SLOT_W-1:0]     mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    pkthc_out_t            out_word;

    assign clearing  = clr_active_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign head_idx = SLOT_W'(head.count_slot);
    assign b_adv    = b_valid_reg && (!out_valid_reg || out_ready);
    assign pop      = !q_status.empty && !clr_active_reg && (!b_valid_reg || b_adv);
    assign b_wr_en  = b_adv && (b_job_reg.count_class != CLASS_NONE);

    // Latest write forwarded over the registered read
    always_comb
    begin
        base_value = (b_job_reg.count_class == CLASS_DROP) ? drop_rd_reg : pass_rd_reg;
        if (fwd_valid_reg && fwd_class_reg == b_job_reg.count_class &&
            fwd_idx_reg == b_idx_reg)
        begin
            base_value = fwd_value_reg;
        end
        bumped = (base_value == '1) ? base_value : base_value + COUNT_BITS'(1);
    end

    // Write port: clearing sweep first, then counter updates
    always_comb
    begin
        if (clr_active_reg)
        begin
            drop_we = 1'b1;
            pass_we = 1'b1;
            mem_wa  = clr_addr_reg;
            mem_wd  = '0;
        end
        else
        begin
            drop_we = b_wr_en && (b_job_reg.count_class == CLASS_DROP);
            pass_we = b_wr_en && (b_job_reg.count_class == CLASS_PASS);
            mem_wa  = b_idx_reg;
            mem_wd  = bumped;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drop_we)
        begin
            drop_mem[mem_wa] <= mem_wd;
        end
        if (pop)
        begin
            drop_rd_reg <= drop_mem[head_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pass_we)
        begin
            pass_mem[mem_wa] <= mem_wd;
        end
        if (pop)
        begin
            pass_rd_reg <= pass_mem[head_idx];
        end
    end

    always_comb
    begin
        out_word                = '0;
        out_word.verdict        = verdict_of(b_job_reg.count_class);
        out_word.ether_kind     = b_job_reg.ether_kind;
        out_word.port_rewritten = b_job_reg.port_rewritten;
        out_word.new_dest_port  = b_job_reg.new_dest_port;
        out_word.port_offset    = b_job_reg.port_offset;
        out_word.count_class    = b_job_reg.count_class;
        out_word.count_slot     = b_job_reg.count_slot;
        if (b_job_reg.count_class != CLASS_NONE)
        begin
            out_word.count_value = 32'(bumped);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b_job_reg <= head;
            b_idx_reg <= head_idx;
        end
        if (b_wr_en)
        begin
            fwd_class_reg <= b_job_reg.count_class;
            fwd_idx_reg   <= b_idx_reg;
            fwd_value_reg <= bumped;
        end
        if (b_adv)
        begin
            out_data_reg <= out_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                if (clr_addr_reg == SLOT_W'(COUNTER_SLOTS - 1))
                begin
                    clr_active_reg <= 1'b0;
                end
                clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
            end
            if (pop)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (b_adv)
            begin
                b_valid_reg <= 1'b0;
            end
            if (b_wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (b_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_idle_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !b_valid_reg && !pop)
        else $error("counter update under way during clearing sweep");

    a_clear_once: assert property (@(posedge clk) disable iff (!rst_n)
        !$rose(clr_active_reg))
        else $error("clearing sweep restarted outside reset");

    a_forward_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
        b_wr_en |=> fwd_valid_reg && fwd_idx_reg == $past(b_idx_reg))
        else $error("forwarding register missed a counter write");

endmodule

/* rtl/core/packet_header_classifier.sv */
// ----------------------------------------------------------------------------
// packet_header_classifier
// Ethernet / IPv4 / IPv6 / TCP / UDP header classifier with per-ethertype
// drop and pass counters.
// ----------------------------------------------------------------------------
// Packet bytes enter on s_axis one per transfer, tlast on the final byte, and
// one result word leaves on m_axis per packet. Bytes are taken every cycle
// while the job queue has room and a result can leave every cycle while
// m_axis is ready, including for back-to-back one-byte packets. Results go
// through the counter stage and the output register; the four-entry job queue
// between the parser and the counter unit absorbs m_axis back-pressure before
// s_axis stalls. The counter unit does one read-modify-write per cycle while
// its result register can advance, on drop and pass memories with separate
// read and write ports, forwarding the latest write over the registered read.
// After reset the counters are zeroed one slot per cycle; s_axis_tready is low.
// Verdicts: pass (pass counter bumped), drop (unknown ethertype, drop counter
// bumped), abort (runt frame, slot beyond the stores or bad UDP header, no
// counter change). Counters saturate and are reported in their low 32 bits.
// ----------------------------------------------------------------------------
module packet_header_classifier
    import pkthc_pkg::*;
#(
    parameter int COUNTER_SLOTS = 256,
    parameter int COUNT_BITS    = 32,
    parameter int POSITION_BITS = 11
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // pkt_byte
    input  logic                          s_axis_tlast,   // last_byte
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // verdict[1:0], ether_kind[17:2], port_rewritten[18], new_dest_port[34:19],
    // port_offset[41:35], count_class[43:42], count_slot[51:44],
    // count_value[83:52], zero pad[87:84]
    output logic [$bits(pkthc_out_t)-1:0] m_axis_tdata
);

    logic                s_accept;
    logic                push;
    logic                pop;
    logic                clearing;
    pkthc_job_t          new_job;
    pkthc_job_t          head_job;
    pkthc_queue_status_t q_status;
    pkthc_out_t          out_word;

    // Hold input while sweeping counters or while the job queue is full
    assign s_axis_tready = !clearing && !q_status.full;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tdata  = out_word;

    // Front: parse each byte, form a job on the final byte
    pkthc_front #(
        .COUNTER_SLOTS (COUNTER_SLOTS),
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (s_accept),
        .pkt_byte  (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .push      (push),
        .job       (new_job)
    );

    // Decouple parsing from counter updates
    pkthc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .job_in (new_job),
        .pop    (pop),
        .head   (head_job),
        .status (q_status)
    );

    // Back: bump the counter, register the result word
    pkthc_back #(
        .COUNTER_SLOTS (COUNTER_SLOTS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head_job),
        .q_status  (q_status),
        .pop       (pop),
        .clearing  (clearing),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_word)
    );

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for packet_header_classifier.
// ----------------------------------------------------------------------------
// Frames go into s_axis a byte per transfer and the single result word per
// frame is checked field by field against a behavioural copy of the parser
// and its saturating counters. A table of directed frames covers the header
// corner cases, then random frames follow, mostly well formed with random
// content and the rest damaged. Both sides idle at random in two of three
// phases, and the receiver holds off for a long stretch once so the queue fills.
// ----------------------------------------------------------------------------
module tb;
    import pkthc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNTER_SLOTS = 256;
    localparam int COUNT_BITS    = 32;
    localparam int POSITION_BITS = 11;
    localparam int POS_MAX       = (1 << POSITION_BITS) - 1;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 600;        // long receiver hold-off
    localparam int TAIL_CYCLES   = 20;         // wait after the drain for stray results
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam int NUM_ROWS      = 25;
    localparam int RANDOM_FRAMES = 120;
    localparam int MIN_BYTES     = 400;

    localparam logic [7:0] PROTO_ICMP = 8'd1;

    // One frame to build: header fields are placed where the frame length
    // allows; every other byte is random. When typed is set, the expected
    // result is taken from the row rather than from the predictor.
    typedef struct packed {
        logic [11:0]  len;
        logic [15:0]  etype;
        logic [3:0]   ihl;
        logic [7:0]   proto;
        logic [3:0]   doff;
        logic [15:0]  dport;
        logic [15:0]  udp_len;
        logic         typed;
        verdict_t     verdict;
        count_class_t cls;
        logic [31:0]  cval;
    } probe_t;

    typedef logic [7:0] byte_q_t[$];

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata  = 8'h00;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [$bits(pkthc_out_t)-1:0] m_tdata;

    always #(CLK_PERIOD / 2) clk = ~clk;

    packet_header_classifier #(
        .COUNTER_SLOTS (COUNTER_SLOTS),
        .COUNT_BITS    (COUNT_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Predictor state: per-frame parse state and the two counter stores
    // ------------------------------------------------------------------------
    logic [POSITION_BITS-1:0] byte_pos      = '0;
    logic [15:0]              ether_acc     = '0;
    net_kind_t                net_kind      = NET_NONE;
    logic [6:0]               ip_hdr_bytes  = '0;
    logic [7:0]               l4_proto      = '0;
    logic [6:0]               l4_start      = '0;
    logic [6:0]               tcp_hdr_bytes = '0;
    logic [15:0]              dport_acc     = '0;
    logic [15:0]              udp_len_acc   = '0;
    logic [COUNT_BITS-1:0]    drop_tally [COUNTER_SLOTS];
    logic [COUNT_BITS-1:0]    pass_tally [COUNTER_SLOTS];

    pkthc_out_t verdicts_due[$];               // expected results, oldest first

    int src_idle_pct = 16;
    int dst_idle_pct = 54;
    bit hold_req     = 1'b0;

    int byte_count    = 0;
    int frame_count   = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int rewrites_seen = 0;
    int stall_cycles  = 0;
    bit ready_seen    = 1'b0;
    int verdict_seen [3] = '{0, 0, 0};

    // ------------------------------------------------------------------------
    // Directed frames. Expected results are typed in for runts, first drops
    // in a slot and malformed UDP; all other rows go through the predictor.
    // Columns: len, ethertype, ihl, proto, doff, dport, udp_len, typed,
    //          verdict, counter class, counter value
    // ------------------------------------------------------------------------
    probe_t plan [NUM_ROWS] = '{
        // runts, two single-byte frames back to back, then one byte short
        '{12'd1,    16'h0000, 4'd5,  PROTO_TCP,  4'd5,  16'h0000, 16'h0000,
          1'b1, VERDICT_ABORT, CLASS_NONE, 32'd0},
        '{12'd1,    16'h0000, 4'd5,  PROTO_TCP,  4'd5,  16'h0000, 16'h0000,
          1'b1, VERDICT_ABORT, CLASS_NONE, 32'd0},
        '{12'd13,   ETH_IPV4, 4'd5,  PROTO_TCP,  4'd5,  16'h0000, 16'h0000,
          1'b1, VERDICT_ABORT, CLASS_NONE, 32'd0},
        // unknown ethertypes: lowest and highest slot, and one beside IPv6
        '{12'd14,   16'h0000, 4'd5,  PROTO_TCP,  4'd5,  16'h0000, 16'h0000,
          1'b1, VERDICT_DROP,  CLASS_DROP, 32'd1},
        '{12'd60,   16'hFFFF, 4'd5,  PROTO_TCP,  4'd5,  16'h0000, 16'h0000,
          1'b1, VERDICT_DROP,  CLASS_DROP, 32'd1},
        '{12'd20,   16'h86DC, 4'd5,  PROTO_TCP,  4'd5,  16'h0000, 16'h0000,
          1'b1, VERDICT_DROP,  CLASS_DROP, 32'd1},
        // IPv4 header too short, IHL too small, IHL at its top with and
        // without room
        '{12'd14,   ETH_IPV4, 4'd5,  PROTO_TCP,  4'd5,  16'h1234, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd33,   ETH_IPV4, 4'd5,  PROTO_TCP,  4'd5,  16'h1234, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd60,   ETH_IPV4, 4'd4,  PROTO_TCP,  4'd5,  16'h1234, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd94,   ETH_IPV4, 4'd15, PROTO_TCP,  4'd5,  16'h0000, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd73,   ETH_IPV4, 4'd15, PROTO_TCP,  4'd5,  16'h0000, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        // TCP: minimal header, data offset too small, largest header
        // one byte short and fitting, truncated header
        '{12'd54,   ETH_IPV4, 4'd5,  PROTO_TCP,  4'd5,  16'h0001, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd60,   ETH_IPV4, 4'd5,  PROTO_TCP,  4'd4,  16'h4321, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd93,   ETH_IPV4, 4'd5,  PROTO_TCP,  4'd15, 16'h5555, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd94,   ETH_IPV4, 4'd5,  PROTO_TCP,  4'd15, 16'hFFFF, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd53,   ETH_IPV4, 4'd5,  PROTO_TCP,  4'd5,  16'hAAAA, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        // UDP: header cut short, length field just below and at the minimum,
        // length field at its top
        '{12'd41,   ETH_IPV4, 4'd5,  PROTO_UDP,  4'd5,  16'h0035, 16'h0010,
          1'b1, VERDICT_ABORT, CLASS_NONE, 32'd0},
        '{12'd42,   ETH_IPV4, 4'd5,  PROTO_UDP,  4'd5,  16'h0035, 16'h0007,
          1'b1, VERDICT_ABORT, CLASS_NONE, 32'd0},
        '{12'd42,   ETH_IPV4, 4'd5,  PROTO_UDP,  4'd5,  16'h0035, 16'h0008,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd64,   ETH_IPV4, 4'd5,  PROTO_UDP,  4'd5,  16'h0035, 16'hFFFF,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        // IPv6: header one byte short, TCP rewrite, UDP cut short
        '{12'd53,   ETH_IPV6, 4'd0,  PROTO_TCP,  4'd5,  16'hABCD, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd74,   ETH_IPV6, 4'd0,  PROTO_TCP,  4'd5,  16'hABCD, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd61,   ETH_IPV6, 4'd0,  PROTO_UDP,  4'd5,  16'h0035, 16'h0020,
          1'b1, VERDICT_ABORT, CLASS_NONE, 32'd0},
        // neither TCP nor UDP, then a frame long enough to pin the position
        '{12'd60,   ETH_IPV4, 4'd5,  PROTO_ICMP, 4'd5,  16'h0000, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0},
        '{12'd2100, ETH_IPV4, 4'd5,  PROTO_TCP,  4'd5,  16'h8000, 16'h0000,
          1'b0, VERDICT_PASS,  CLASS_PASS, 32'd0}
    };

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [COUNT_BITS-1:0] bump_tally(logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Advance the parse by one byte. On the final byte of a frame, return 1
    // with the expected result and clear the per-frame state.
    function automatic bit classify_byte(input logic [7:0] b, input bit last,
                                         output pkthc_out_t res);
        int p;
        int t;
        int len;
        int slot;
        bit ip_ok;
        bit udp_bad;
        res             = '0;
        res.verdict     = VERDICT_ABORT;
        res.count_class = CLASS_NONE;
        p               = byte_pos;

        // Capture the header fields as they stream past
        if (p == OFS_ETHERTYPE_HI) begin
            ether_acc = {b, 8'h00};
        end
        else if (p == OFS_ETHERTYPE_LO) begin
            ether_acc[7:0] = b;
            if (ether_acc == ETH_IPV4) begin
                net_kind = NET_IPV4;
            end
            else if (ether_acc == ETH_IPV6) begin
                net_kind = NET_IPV6;
                l4_start = 7'(IPV6_TRANSPORT_START);
            end
            else begin
                net_kind = NET_OTHER;
            end
        end
        else if (p == OFS_IPV4_IHL && net_kind == NET_IPV4) begin
            ip_hdr_bytes = {1'b0, b[3:0], 2'b00};
            l4_start     = 7'(ETH_HDR_LEN) + ip_hdr_bytes;
        end
        else if ((p == OFS_IPV4_PROTO && net_kind == NET_IPV4) ||
                 (p == OFS_IPV6_NEXT_HDR && net_kind == NET_IPV6)) begin
            l4_proto = b;
        end

        // Transport fields, once the transport header position is known
        t = l4_start;
        if ((net_kind == NET_IPV4 || net_kind == NET_IPV6) && t >= MIN_TRANSPORT_START)
        begin
            if (p == t + OFS_L4_PORT_HI)      dport_acc      = {b, 8'h00};
            else if (p == t + OFS_L4_PORT_LO) dport_acc[7:0] = b;
            else if (p == t + OFS_UDP_LEN_HI) udp_len_acc    = {b, 8'h00};
            else if (p == t + OFS_UDP_LEN_LO) udp_len_acc[7:0] = b;
            else if (p == t + OFS_TCP_DOFF)   tcp_hdr_bytes  = {1'b0, b[7:4], 2'b00};
        end

        if (!last) begin
            if (p < POS_MAX) byte_pos = byte_pos + 1'b1;
            return 1'b0;
        end

        len  = p + 1;
        slot = ether_acc[15:8];
        if (len >= ETH_HDR_LEN) begin
            res.ether_kind = ether_acc;
            res.count_slot = ether_acc[15:8];
            if (slot < COUNTER_SLOTS) begin
                if (net_kind == NET_OTHER) begin
                    drop_tally[slot] = bump_tally(drop_tally[slot]);
                    res.verdict      = VERDICT_DROP;
                    res.count_class  = CLASS_DROP;
                    res.count_value  = 32'(drop_tally[slot]);
                end
                else begin
                    if (net_kind == NET_IPV6)
                        ip_ok = (len >= IPV6_MIN_LEN);
                    else
                        ip_ok = (len >= IPV4_MIN_LEN) && (ip_hdr_bytes >= IPV4_MIN_HDR) &&
                                (ETH_HDR_LEN + ip_hdr_bytes <= len);
                    udp_bad = 1'b0;
                    if (ip_ok && l4_proto == PROTO_UDP) begin
                        udp_bad = (len < t + UDP_HDR_LEN) || (udp_len_acc < UDP_HDR_LEN);
                    end
                    else if (ip_ok && l4_proto == PROTO_TCP && len >= t + TCP_MIN_HDR &&
                             tcp_hdr_bytes >= TCP_MIN_HDR && t + tcp_hdr_bytes <= len)
                    begin
                        res.port_rewritten = 1'b1;
                        res.new_dest_port  = dport_acc - 16'd1;
                        res.port_offset    = 7'(t + OFS_L4_PORT_HI);
                    end
                    if (!udp_bad) begin
                        pass_tally[slot] = bump_tally(pass_tally[slot]);
                        res.verdict      = VERDICT_PASS;
                        res.count_class  = CLASS_PASS;
                        res.count_value  = 32'(pass_tally[slot]);
                    end
                end
            end
        end

        byte_pos      = '0;
        ether_acc     = '0;
        net_kind      = NET_NONE;
        ip_hdr_bytes  = '0;
        l4_proto      = '0;
        l4_start      = '0;
        tcp_hdr_bytes = '0;
        dport_acc     = '0;
        udp_len_acc   = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Frame construction
    // ------------------------------------------------------------------------
    function automatic void place(ref byte_q_t q, input int idx, input logic [7:0] v);
        if (idx < q.size()) q[idx] = v;
    endfunction

    function automatic byte_q_t build_frame(probe_t f);
        byte_q_t q;
        int      ts;
        for (int i = 0; i < f.len; i++) q.push_back(8'($urandom));
        ts = 0;
        place(q, OFS_ETHERTYPE_HI, f.etype[15:8]);
        place(q, OFS_ETHERTYPE_LO, f.etype[7:0]);
        if (f.etype == ETH_IPV4) begin
            ts = ETH_HDR_LEN + 4 * f.ihl;
            place(q, OFS_IPV4_IHL, {4'h4, f.ihl});
            place(q, OFS_IPV4_PROTO, f.proto);
        end
        else if (f.etype == ETH_IPV6) begin
            ts = IPV6_TRANSPORT_START;
            place(q, OFS_IPV6_NEXT_HDR, f.proto);
        end
        // Leave the transport bytes random when IHL puts them inside the IP header
        if (ts >= MIN_TRANSPORT_START) begin
            place(q, ts + OFS_L4_PORT_HI, f.dport[15:8]);
            place(q, ts + OFS_L4_PORT_LO, f.dport[7:0]);
            place(q, ts + OFS_UDP_LEN_HI, f.udp_len[15:8]);
            place(q, ts + OFS_UDP_LEN_LO, f.udp_len[7:0]);
            place(q, ts + OFS_TCP_DOFF, {f.doff, 4'($urandom)});
        end
        return q;
    endfunction

    // Mostly well-formed IPv4 and IPv6 frames sized to hold their transport
    // header; about a fifth are damaged in one way or another.
    function automatic probe_t random_frame();
        probe_t f;
        int     mode;
        int     ts;
        int     len;
        f         = '0;
        mode      = $urandom_range(99);
        f.etype   = (mode >= 65 && mode < 80) ? ETH_IPV6 : ETH_IPV4;
        f.ihl     = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : 4'd5;
        f.proto   = $urandom_range(1) ? PROTO_TCP : PROTO_UDP;
        f.doff    = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : 4'd5;
        f.dport   = 16'($urandom);
        f.udp_len = 16'($urandom_range(65535, UDP_HDR_LEN));
        ts  = (f.etype == ETH_IPV6) ? IPV6_TRANSPORT_START : ETH_HDR_LEN + 4 * f.ihl;
        len = ts + ((f.proto == PROTO_TCP) ? 4 * f.doff : UDP_HDR_LEN) + $urandom_range(24);

        if (mode >= 80 && mode < 84) begin          // unknown ethertype
            f.etype = 16'($urandom);
            len     = $urandom_range(60, ETH_HDR_LEN);
        end
        else if (mode >= 84 && mode < 87) begin     // runt
            len = $urandom_range(ETH_HDR_LEN - 1, 1);
        end
        else if (mode >= 87 && mode < 90) begin     // IHL below five words
            f.ihl = 4'($urandom_range(4));
            len   = $urandom_range(60, ETH_HDR_LEN);
        end
        else if (mode >= 90 && mode < 94) begin     // cut off inside the headers
            len = $urandom_range(len - 1, ETH_HDR_LEN);
        end
        else if (mode >= 94 && mode < 97) begin     // bad data offset or UDP length
            f.doff    = 4'($urandom_range(4));
            f.udp_len = 16'($urandom_range(UDP_HDR_LEN - 1));
        end
        else if (mode >= 97) begin                  // any protocol number
            f.proto = 8'($urandom);
        end
        f.len = 12'(len);
        return f;
    endfunction

    // ------------------------------------------------------------------------
    // Sender: one byte per transfer, random gaps, inputs change on the
    // falling edge and the handshake is sampled on the rising edge
    // ------------------------------------------------------------------------
    task automatic send_frame(input probe_t f);
        byte_q_t    q;
        pkthc_out_t res;
        bit         last;
        q = build_frame(f);
        foreach (q[i]) begin
            last = (i == q.size() - 1);
            while ($urandom_range(99) < src_idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= q[i];
            s_tlast  <= last;
            do @(posedge clk); while (!s_tready);
            byte_count++;
            if (classify_byte(q[i], last, res)) begin
                // Typed rows replace the prediction but the counters still advance
                if (f.typed) begin
                    res             = '0;
                    res.verdict     = f.verdict;
                    res.count_class = f.cls;
                    res.count_value = f.cval;
                    if (f.len >= ETH_HDR_LEN) begin
                        res.ether_kind = f.etype;
                        res.count_slot = f.etype[15:8];
                    end
                end
                verdicts_due.push_back(res);
            end
            @(negedge clk);
        end
        frame_count++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure, plus one long hold-off on request
    // ------------------------------------------------------------------------
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else begin
                m_tready <= ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d: %s expected %h, got %h", results_seen, name, want, got);
        end
    endfunction

    always @(posedge clk) begin
        pkthc_out_t got;
        pkthc_out_t want;
        if (rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (verdicts_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d arrived with nothing expected: %h",
                             results_seen, m_tdata);
            end
            else begin
                want = verdicts_due.pop_front();
                check_field("verdict",        32'(want.verdict),        32'(got.verdict));
                check_field("ether_kind",     32'(want.ether_kind),     32'(got.ether_kind));
                check_field("port_rewritten", 32'(want.port_rewritten), 32'(got.port_rewritten));
                check_field("new_dest_port",  32'(want.new_dest_port),  32'(got.new_dest_port));
                check_field("port_offset",    32'(want.port_offset),    32'(got.port_offset));
                check_field("count_class",    32'(want.count_class),    32'(got.count_class));
                check_field("count_slot",     32'(want.count_slot),     32'(got.count_slot));
                check_field("count_value",    want.count_value,         got.count_value);
                verdict_seen[want.verdict]++;
                rewrites_seen += want.port_rewritten;
            end
            results_seen++;
        end
    end

    // Count cycles on which the block refuses an offered byte, once it has
    // finished clearing its counters
    always @(posedge clk) begin
        if (s_tready)
            ready_seen = 1'b1;
        else if (s_tvalid && ready_seen)
            stall_cycles++;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        foreach (drop_tally[i]) begin
            drop_tally[i] = '0;
            pass_tally[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table; the sender waits out the counter clearing pass
        for (int r = 0; r < NUM_ROWS; r++) send_frame(plan[r]);

        // Random frames in three idling phases; the last opens with a long
        // receiver hold-off, fed with runts so the job queue fills quickly
        for (int n = 0; n < RANDOM_FRAMES || byte_count < MIN_BYTES; n++) begin
            if (n == RANDOM_FRAMES / 3) begin
                src_idle_pct = 54;
                dst_idle_pct = 16;
            end
            if (n == 2 * RANDOM_FRAMES / 3) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
                hold_req     = 1'b1;
            end
            if (hold_req) begin
                send_frame('{12'($urandom_range(ETH_HDR_LEN - 1, 1)), 16'h0000, 4'd5,
                             PROTO_TCP, 4'd5, 16'h0000, 16'h0000, 1'b0,
                             VERDICT_ABORT, CLASS_NONE, 32'd0});
            end
            else begin
                send_frame(random_frame());
            end
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain, then keep watching for anything stray
        while (verdicts_due.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d frames in %0d byte transfers: %0d pass, %0d drop, %0d abort, %0d rewrites",
                 frame_count, byte_count, verdict_seen[VERDICT_PASS],
                 verdict_seen[VERDICT_DROP], verdict_seen[VERDICT_ABORT], rewrites_seen);
        $display("input stalled on %0d cycles; %0d results checked, %0d mismatches",
                 stall_cycles, results_seen, mismatches);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("tb passed");
        end
        else begin
            $display("tb failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", verdicts_due.size());
        $display("tb failed");
        $finish;
    end

endmodule

/* packet_header_classifier.f */
rtl/core/pkthc_pkg.sv
rtl/core/pkthc_front.sv
rtl/core/pkthc_queue.sv
rtl/core/pkthc_back.sv
rtl/core/packet_header_classifier.sv
bench/tb.sv
